>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

>>> rtl/blpg_pkg.sv
// Shared types and codes for the line point generator.
// No dependencies; used by the setup unit and the top level.
package blpg_pkg;

    // command codes carried in the func field
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // per-axis step direction, two's complement -1/0/+1
    typedef logic [1:0] t_step;
    localparam t_step STEP_ZERO = 2'b00;
    localparam t_step STEP_POS  = 2'b01;
    localparam t_step STEP_NEG  = 2'b11;

    // direction control of one line
    typedef struct packed {
        t_step step_x;
        t_step step_y;
        logic  swap;    // major axis is y
    } t_dir;

endpackage

>>> rtl/blpg_cmd_if.sv
// Command channel of the line point generator: valid/ready plus endpoints.
// No dependencies.
interface blpg_cmd_if #(
    parameter int COORD_BITS = 11
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, func, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> rtl/blpg_pt_if.sv
// Point channel of the line point generator: valid/ready plus one point.
// No dependencies.
interface blpg_pt_if #(
    parameter int COORD_BITS = 11
);
    logic                         valid;
    logic                         ready;
    logic                         valid_res;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last;

    modport source (output valid, valid_res, point_x, point_y, last, input ready);
    modport sink   (input valid, valid_res, point_x, point_y, last, output ready);
endinterface

>>> rtl/blpg_setup.sv
// Line setup: deltas, step signs, axis swap and initial error from endpoints.
// Depends on blpg_pkg. Purely combinational.
module blpg_setup import blpg_pkg::*; #(
    parameter int COORD_BITS = 11
) (
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    output logic        [COORD_BITS:0]   o_major,
    output logic        [COORD_BITS:0]   o_minor,
    output logic signed [COORD_BITS+2:0] o_err,
    output t_dir                         o_dir
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic        [COORD_BITS:0] abs_dx;
    logic        [COORD_BITS:0] abs_dy;
    logic                       swap;

    // signed differences, one bit wider than the coordinates
    assign dx = {i_end_x[COORD_BITS-1], i_end_x} - {i_start_x[COORD_BITS-1], i_start_x};
    assign dy = {i_end_y[COORD_BITS-1], i_end_y} - {i_start_y[COORD_BITS-1], i_start_y};

    assign abs_dx = dx[COORD_BITS] ? -dx : dx;
    assign abs_dy = dy[COORD_BITS] ? -dy : dy;

    // y is the major axis only when strictly steeper
    assign swap = abs_dy > abs_dx;

    assign o_major = swap ? abs_dy : abs_dx;
    assign o_minor = swap ? abs_dx : abs_dy;

    // 2*minor - major
    assign o_err = $signed({1'b0, o_minor, 1'b0}) - $signed({2'b00, o_major});

    always_comb begin
        o_dir.swap   = swap;
        o_dir.step_x = dx[COORD_BITS] ? STEP_NEG : ((dx != '0) ? STEP_POS : STEP_ZERO);
        o_dir.step_y = dy[COORD_BITS] ? STEP_NEG : ((dy != '0) ? STEP_POS : STEP_ZERO);
    end

endmodule

>>> rtl/bresenham_line_point_generator.sv
// Bresenham line point generator, all octants, one result beat per command beat.
// Depends on blpg_pkg, blpg_cmd_if, blpg_pt_if, blpg_setup, assert_macros.svh.
//
// Usage:
//   i_cmd carries commands. func = start loads two signed endpoints and
//   returns the start point; func = advance returns the next point of the
//   line. The point whose coordinates equal the end point has last = 1.
//   An advance with no line in progress returns a beat with valid_res = 0
//   and zero point fields; a start always replaces any line in progress.
//   o_pt carries exactly one result beat for every accepted command.
// Timing:
//   A command's result appears on o_pt in the cycle after it is accepted.
//   One command per cycle is accepted while o_pt does not stall; the step of
//   the error term and the coordinate update are combinational from line state.
//   When o_pt stalls, the result register holds and i_cmd.ready drops until
//   the waiting beat is taken; a beat taken frees the register in the same
//   cycle, so a new command is accepted alongside it.
// Reset:
//   Synchronous, active low. No line is active and o_pt is empty afterwards.
`include "assert_macros.svh"

module bresenham_line_point_generator import blpg_pkg::*; #(
    parameter int COORD_BITS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blpg_cmd_if.sink    i_cmd,
    blpg_pt_if.source   o_pt
);

    localparam int DW = COORD_BITS + 1;   // delta and count width
    localparam int EW = COORD_BITS + 3;   // error term width

    // line state
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic signed [EW-1:0]         r_err, n_err;
    logic        [DW-1:0]         r_major, n_major;
    logic        [DW-1:0]         r_minor, n_minor;
    t_dir                         r_dir, n_dir;
    logic        [DW-1:0]         r_points_left, n_points_left;
    logic                         r_active, n_active;

    // result register
    logic                         r_out_valid, n_out_valid;
    logic                         r_res_valid, n_res_valid;
    logic signed [COORD_BITS-1:0] r_pt_x, n_pt_x;
    logic signed [COORD_BITS-1:0] r_pt_y, n_pt_y;
    logic                         r_last, n_last;

    logic                         cmd_acc;

    // setup outputs
    logic        [DW-1:0]         su_major;
    logic        [DW-1:0]         su_minor;
    logic signed [EW-1:0]         su_err;
    t_dir                         su_dir;

    // advance datapath
    logic                         err_ge;
    logic signed [COORD_BITS-1:0] inc_x;
    logic signed [COORD_BITS-1:0] inc_y;
    logic signed [COORD_BITS-1:0] adv_x;
    logic signed [COORD_BITS-1:0] adv_y;
    logic signed [EW-1:0]         adv_err;
    logic        [DW-1:0]         adv_left;

    blpg_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_start_x (i_cmd.start_x),
        .i_start_y (i_cmd.start_y),
        .i_end_x   (i_cmd.end_x),
        .i_end_y   (i_cmd.end_y),
        .o_major   (su_major),
        .o_minor   (su_minor),
        .o_err     (su_err),
        .o_dir     (su_dir)
    );

    // handshake: take a command whenever the result register is free or drains
    assign i_cmd.ready = !r_out_valid || o_pt.ready;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;

    // one Bresenham step from the current state
    assign err_ge = !r_err[EW-1];
    assign inc_x  = (!r_dir.swap || err_ge) ?
                    {{(COORD_BITS-2){r_dir.step_x[1]}}, r_dir.step_x} : '0;
    assign inc_y  = (r_dir.swap || err_ge) ?
                    {{(COORD_BITS-2){r_dir.step_y[1]}}, r_dir.step_y} : '0;
    assign adv_x  = r_cur_x + inc_x;
    assign adv_y  = r_cur_y + inc_y;
    assign adv_err = r_err + $signed({1'b0, r_minor, 1'b0})
                   - (err_ge ? $signed({1'b0, r_major, 1'b0}) : $signed(EW'(0)));
    assign adv_left = r_points_left - DW'(1);

    // next state and result
    always_comb begin
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_err         = r_err;
        n_major       = r_major;
        n_minor       = r_minor;
        n_dir         = r_dir;
        n_points_left = r_points_left;
        n_active      = r_active;
        n_res_valid   = r_res_valid;
        n_pt_x        = r_pt_x;
        n_pt_y        = r_pt_y;
        n_last        = r_last;
        n_out_valid   = r_out_valid && !o_pt.ready;

        if (cmd_acc) begin
            n_out_valid = 1'b1;
            if (i_cmd.func == FUNC_START) begin
                n_cur_x       = i_cmd.start_x;
                n_cur_y       = i_cmd.start_y;
                n_err         = su_err;
                n_major       = su_major;
                n_minor       = su_minor;
                n_dir         = su_dir;
                n_points_left = su_major;
                n_active      = (su_major != '0);
                n_res_valid   = 1'b1;
                n_pt_x        = i_cmd.start_x;
                n_pt_y        = i_cmd.start_y;
                n_last        = (su_major == '0);
            end else if (r_active) begin
                n_cur_x       = adv_x;
                n_cur_y       = adv_y;
                n_err         = adv_err;
                n_points_left = adv_left;
                n_active      = (adv_left != '0);
                n_res_valid   = 1'b1;
                n_pt_x        = adv_x;
                n_pt_y        = adv_y;
                n_last        = (adv_left == '0);
            end else begin
                // advance with nothing to draw
                n_res_valid   = 1'b0;
                n_pt_x        = '0;
                n_pt_y        = '0;
                n_last        = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_points_left <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_active      <= n_active;
            r_points_left <= n_points_left;
            r_out_valid   <= n_out_valid;
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_err       <= n_err;
        r_major     <= n_major;
        r_minor     <= n_minor;
        r_dir       <= n_dir;
        r_res_valid <= n_res_valid;
        r_pt_x      <= n_pt_x;
        r_pt_y      <= n_pt_y;
        r_last      <= n_last;
    end

    assign o_pt.valid     = r_out_valid;
    assign o_pt.valid_res = r_res_valid;
    assign o_pt.point_x   = r_pt_x;
    assign o_pt.point_y   = r_pt_y;
    assign o_pt.last      = r_last;

    // checks
    `ASSERT_ALWAYS(a_active_matches_count, i_clk, i_rst_n,
        r_active == (r_points_left != '0), "active flag disagrees with point count")

    `ASSERT_NEVER(a_empty_beat_clean, i_clk, i_rst_n,
        o_pt.valid && !o_pt.valid_res && (o_pt.last || o_pt.point_x != '0 ||
        o_pt.point_y != '0), "empty result beat carries point data")

    `ASSERT_NEVER(a_stall_blocks_cmd, i_clk, i_rst_n,
        o_pt.valid && !o_pt.ready && i_cmd.ready, "command taken while result stalls")

    `ASSERT_ALWAYS(a_point_line_last, i_clk, i_rst_n,
        (cmd_acc && i_cmd.func == FUNC_START && i_cmd.start_x == i_cmd.end_x &&
        i_cmd.start_y == i_cmd.end_y) |=> (o_pt.valid && o_pt.valid_res && o_pt.last),
        "single point line not flagged last")

endmodule

>>> bench/tb.sv
// Self-checking bench for bresenham_line_point_generator: a directed table, then random lines.
// Depends on blpg_pkg, blpg_cmd_if, blpg_pt_if and the RTL of the block.
module tb import blpg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS      = 11;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int RANDOM_PHASES   = 4;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int LONG_HOLD       = 300;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic   func;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_cmd_beat;

    typedef struct packed {
        logic   valid_res;
        t_coord point_x;
        t_coord point_y;
        logic   last;
    } t_point;

    typedef struct packed {
        t_cmd_beat beat;
        logic      has_want;
        t_point    want;
    } t_line_row;

    logic i_clk;
    logic i_rst_n;

    blpg_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
    blpg_pt_if  #(.COORD_BITS(COORD_BITS)) pt_ch ();

    bresenham_line_point_generator #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_pt    (pt_ch)
    );

    // typed expectation that travels with the beat on offer
    logic   beat_has_want;
    t_point beat_want;

    t_point expected_points [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    int mismatch_count;
    int quiet_cycles;
    int lines_started;
    int points_seen;
    int empty_seen;
    int ends_seen;

    // line state of the predictor, at the block's widths
    t_coord                     ln_x      = '0;
    t_coord                     ln_y      = '0;
    logic signed [COORD_BITS+2:0] ln_err  = '0;
    logic [COORD_BITS:0]        ln_major  = '0;
    logic [COORD_BITS:0]        ln_minor  = '0;
    logic [COORD_BITS:0]        ln_left   = '0;
    t_step                      ln_step_x = STEP_ZERO;
    t_step                      ln_step_y = STEP_ZERO;
    logic                       ln_swap   = 1'b0;
    logic                       ln_active = 1'b0;

    // directed table; rows with has_want = 0 are checked against the predictor
    t_line_row line_rows [25] = '{
        // advance with no line in progress
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b1, '{1'b0, 11'sd0, 11'sd0, 1'b0}},
        // start equals end: single point, flagged last
        '{'{FUNC_START, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b1, '{1'b1, 11'sd0, 11'sd0, 1'b1}},
        '{'{FUNC_ADVANCE, -11'sd1, -11'sd1, -11'sd1, -11'sd1}, 1'b1,
          '{1'b0, 11'sd0, 11'sd0, 1'b0}},
        // full-range diagonal, corners of the box
        '{'{FUNC_START, -11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023}, 1'b1,
          '{1'b1, -11'sd1024, -11'sd1024, 1'b0}},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        // restart while a line is in progress, opposite corners
        '{'{FUNC_START, 11'sd1023, -11'sd1024, -11'sd1024, 11'sd1023}, 1'b1,
          '{1'b1, 11'sd1023, -11'sd1024, 1'b0}},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        // horizontal, dropped by the next start
        '{'{FUNC_START, -11'sd1024, 11'sd0, 11'sd1023, 11'sd0}, 1'b1,
          '{1'b1, -11'sd1024, 11'sd0, 1'b0}},
        // shallow line run to its end and beyond
        '{'{FUNC_START, 11'sd0, 11'sd0, 11'sd3, 11'sd1}, 1'b1, '{1'b1, 11'sd0, 11'sd0, 1'b0}},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b1, '{1'b1, 11'sd3, 11'sd1, 1'b1}},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b1, '{1'b0, 11'sd0, 11'sd0, 1'b0}},
        // steep line, both steps negative
        '{'{FUNC_START, 11'sd10, 11'sd10, 11'sd7, 11'sd2}, 1'b1, '{1'b1, 11'sd10, 11'sd10, 1'b0}},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b1, '{1'b1, 11'sd7, 11'sd2, 1'b1}},
        // vertical line, zero x step
        '{'{FUNC_START, -11'sd5, 11'sd7, -11'sd5, 11'sd9}, 1'b1, '{1'b1, -11'sd5, 11'sd7, 1'b0}},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b0, '0},
        '{'{FUNC_ADVANCE, 11'sd0, 11'sd0, 11'sd0, 11'sd0}, 1'b1, '{1'b1, -11'sd5, 11'sd9, 1'b1}}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_step step_of(int d);
        if (d < 0) return STEP_NEG;
        if (d > 0) return STEP_POS;
        return STEP_ZERO;
    endfunction

    // next point of the line for one command beat; updates the line state
    function automatic t_point rasterize_beat(t_cmd_beat c);
        int     dx;
        int     dy;
        t_point p;
        p = '0;
        if (c.func == FUNC_START) begin
            dx = int'(c.end_x) - int'(c.start_x);
            dy = int'(c.end_y) - int'(c.start_y);
            ln_step_x = step_of(dx);
            ln_step_y = step_of(dy);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            ln_swap   = (dy > dx);
            ln_major  = (COORD_BITS+1)'(ln_swap ? dy : dx);
            ln_minor  = (COORD_BITS+1)'(ln_swap ? dx : dy);
            ln_err    = (COORD_BITS+3)'(2 * int'(ln_minor) - int'(ln_major));
            ln_x      = c.start_x;
            ln_y      = c.start_y;
            ln_left   = ln_major;
            ln_active = (ln_left != 0);
            p = '{1'b1, ln_x, ln_y, !ln_active};
        end else if (ln_active) begin
            // minor axis steps when the error is not negative
            if (ln_err >= 0) begin
                if (ln_swap) ln_x = ln_x + $signed(ln_step_x);
                else         ln_y = ln_y + $signed(ln_step_y);
                ln_err = (COORD_BITS+3)'(int'(ln_err) - 2 * int'(ln_major));
            end
            if (ln_swap) ln_y = ln_y + $signed(ln_step_y);
            else         ln_x = ln_x + $signed(ln_step_x);
            ln_err    = (COORD_BITS+3)'(int'(ln_err) + 2 * int'(ln_minor));
            ln_left   = ln_left - 1'b1;
            ln_active = (ln_left != 0);
            p = '{1'b1, ln_x, ln_y, !ln_active};
        end
        return p;
    endfunction

    function automatic void check_field(string name, logic signed [15:0] want,
                                        logic signed [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // scoreboard and watchdog; results are checked before the new beat is predicted
    always @(posedge i_clk) begin : monitor
        t_point got;
        t_point want;
        if (i_rst_n) begin
            if (pt_ch.valid && pt_ch.ready) begin
                got = '{pt_ch.valid_res, pt_ch.point_x, pt_ch.point_y, pt_ch.last};
                if (expected_points.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %0b %0d %0d %0b",
                             $time, got.valid_res, got.point_x, got.point_y, got.last);
                    mismatch_count++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("valid_res", 16'(want.valid_res), 16'(got.valid_res));
                    check_field("point_x", 16'(want.point_x), 16'(got.point_x));
                    check_field("point_y", 16'(want.point_y), 16'(got.point_y));
                    check_field("last", 16'(want.last), 16'(got.last));
                end
                if (got.valid_res === 1'b1) points_seen++;
                else empty_seen++;
                if (got.valid_res === 1'b1 && got.last === 1'b1) ends_seen++;
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                want = rasterize_beat('{cmd_ch.func, cmd_ch.start_x, cmd_ch.start_y,
                                        cmd_ch.end_x, cmd_ch.end_y});
                if (beat_has_want) want = beat_want;
                expected_points.push_back(want);
                if (cmd_ch.func == FUNC_START) lines_started++;
            end
            if ((pt_ch.valid && pt_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_CYCLES) begin
                    $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                    $display("Mismatches found");
                    $finish;
                end
            end
        end
    end

    // point sink: random stalls, plus a long hold-off on request
    initial begin : receiver
        int n;
        pt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                pt_ch.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                pt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one command beat, idling first at the current rate
    task automatic send_beat(t_cmd_beat c, logic has_want, t_point want);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.func    <= c.func;
        cmd_ch.start_x <= c.start_x;
        cmd_ch.start_y <= c.start_y;
        cmd_ch.end_x   <= c.end_x;
        cmd_ch.end_y   <= c.end_y;
        beat_has_want  <= has_want;
        beat_want      <= want;
        @(posedge i_clk);
        while (!(cmd_ch.valid && cmd_ch.ready)) @(posedge i_clk);
    endtask

    task automatic send_predicted(t_cmd_beat c);
        send_beat(c, 1'b0, '0);
    endtask

    // sender stops until every expected point has come back
    task automatic drain_points();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_points.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic t_coord coord_near(t_coord base);
        int v;
        v = int'(base) + int'($urandom_range(16)) - 8;
        if (v < -(1 << (COORD_BITS - 1))) v = -(1 << (COORD_BITS - 1));
        if (v > (1 << (COORD_BITS - 1)) - 1) v = (1 << (COORD_BITS - 1)) - 1;
        return t_coord'(v);
    endfunction

    // random lines: mostly short and run to the end, some cut short, overrun, or noise
    task automatic run_random_lines(int n_items);
        t_cmd_beat c;
        int        sent;
        int        n_adv;
        int        dx;
        int        dy;
        int        pick;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 8) begin
                c = '{FUNC_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                      t_coord'($urandom), t_coord'($urandom)};
                send_predicted(c);
                sent++;
            end else begin
                c.func    = FUNC_START;
                c.start_x = t_coord'($urandom);
                c.start_y = t_coord'($urandom);
                if ($urandom_range(9) == 0) begin
                    c.end_x = t_coord'($urandom);
                    c.end_y = t_coord'($urandom);
                end else begin
                    c.end_x = coord_near(c.start_x);
                    c.end_y = coord_near(c.start_y);
                end
                dx = int'(c.end_x) - int'(c.start_x);
                dy = int'(c.end_y) - int'(c.start_y);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                n_adv = (dx > dy) ? dx : dy;
                pick  = $urandom_range(99);
                if (n_adv > 24) n_adv = $urandom_range(24);
                else if (pick < 12) n_adv = $urandom_range(n_adv);
                else if (pick < 27) n_adv = n_adv + $urandom_range(3, 1);
                send_predicted(c);
                repeat (n_adv) begin
                    c = '{FUNC_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                          t_coord'($urandom), t_coord'($urandom)};
                    send_predicted(c);
                end
                sent += 1 + n_adv;
            end
        end
    endtask

    // stimulus
    initial begin
        int idle_by_phase  [RANDOM_PHASES] = '{0, 72, 0, 34};
        int stall_by_phase [RANDOM_PHASES] = '{0, 0, 72, 34};
        mismatch_count = 0;
        quiet_cycles   = 0;
        lines_started  = 0;
        points_seen    = 0;
        empty_seen     = 0;
        ends_seen      = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.func    <= FUNC_ADVANCE;
        cmd_ch.start_x <= '0;
        cmd_ch.start_y <= '0;
        cmd_ch.end_x   <= '0;
        cmd_ch.end_y   <= '0;
        beat_has_want  <= 1'b0;
        beat_want      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (line_rows[i]) send_beat(line_rows[i].beat, line_rows[i].has_want,
                                         line_rows[i].want);
        drain_points();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            // long sink hold-off while commands keep coming, so the input backs up
            if (p == 0) hold_cycles = LONG_HOLD;
            run_random_lines(ITEMS_PER_PHASE);
            drain_points();
        end

        repeat (4) @(posedge i_clk);
        $display("Covered %0d line starts, %0d points (%0d line ends), %0d empty advances,",
                 lines_started, points_seen, ends_seen, empty_seen);
        $display("over phases with no idling, sender gaps, sink stalls and both combined.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/blpg_pkg.sv
rtl/blpg_cmd_if.sv
rtl/blpg_pt_if.sv
rtl/blpg_setup.sv
rtl/bresenham_line_point_generator.sv
bench/tb.sv
